// File: sv/tvsl_pkg.sv
// ----------------------------------------------------------------------------
// tvsl_pkg
// Shared types and constants for the touch virtual stick and look unit.
// ----------------------------------------------------------------------------
package tvsl_pkg;

  // Event kinds carried on the input sideband
  typedef enum logic [2:0] {
    CMD_DOWN    = 3'd0,
    CMD_MOVE    = 3'd1,
    CMD_UP      = 3'd2,
    CMD_CANCEL  = 3'd3,
    CMD_CONFIRM = 3'd4,
    CMD_CONSUME = 3'd5
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] CFG_DEADZONE   = 2'd1;
  localparam logic [1:0] CFG_TAP_TRAVEL = 2'd2;
  localparam logic [1:0] CFG_TAP_TIME   = 2'd3;

  // Field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned IN_W    = 72;
  localparam int unsigned OUT_W   = 88;
  localparam int unsigned MAG_W   = 7;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned STICK_W = 16;
  localparam int unsigned ORBIT_W = 26;
  localparam int unsigned TILT_W  = 25;

  // Stick travel for full deflection, and 16384/70 as a 2^-16 scaled reciprocal
  localparam logic [MAG_W-1:0] STICK_RADIUS = 7'd70;
  localparam logic [23:0]      DEFL_RECIP   = 24'd15339169;
  localparam int unsigned      DEFL_SHIFT   = 16;

  // Pixel-to-radian scales in Q.16 with seven extra fraction bits
  localparam logic [17:0] ORBIT_MUL = 18'd67109;
  localparam logic [17:0] TILT_MUL  = 18'd41943;

  // Pixel sum clamp
  localparam logic signed [SUM_W:0] SUM_LIMIT = 17'sd32767;

  // One accepted input word
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   touch_id;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [TIME_W-1:0] time_us;
  } item_t;

  // State captured at a consume, handed to the scaling stage
  typedef struct packed {
    logic                    fwd_neg;
    logic [MAG_W-1:0]        fwd_mag;
    logic                    str_neg;
    logic [MAG_W-1:0]        str_mag;
    logic signed [SUM_W-1:0] orbit_sum;
    logic signed [SUM_W-1:0] tilt_sum;
    logic                    jump;
  } snap_t;

endpackage

// File: sv/tvsl_track.sv
// ----------------------------------------------------------------------------
// tvsl_track
// Input register, configuration registers and finger tracking state. Each
// accepted word updates the state as it leaves the input register; a consume
// also captures a snapshot for the scaling stage.
// ----------------------------------------------------------------------------
module tvsl_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tvsl_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [tvsl_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tvsl_pkg::item_t              in_item,
  output logic                         snap_valid,
  input  logic                         snap_ready,
  output tvsl_pkg::snap_t              snap
);

  typedef struct packed {
    logic                        neg;
    logic [tvsl_pkg::MAG_W-1:0]  mag;
  } defl_t;

  // Deadzone and clamp of one stick axis offset
  function automatic defl_t defl_prep(input logic [tvsl_pkg::POS_W-1:0] cur,
                                      input logic [tvsl_pkg::POS_W-1:0] org,
                                      input logic [7:0]                 dz);
    logic signed [tvsl_pkg::POS_W:0] d;
    logic [tvsl_pkg::POS_W-1:0]      m;
    defl_t                           r;
    d = $signed({1'b0, cur}) - $signed({1'b0, org});
    m = d[tvsl_pkg::POS_W] ? tvsl_pkg::POS_W'(-d) : d[tvsl_pkg::POS_W-1:0];
    r.neg = d[tvsl_pkg::POS_W];
    if (m < {4'd0, dz}) begin
      r.mag = '0;
    end else if (m > {5'd0, tvsl_pkg::STICK_RADIUS}) begin
      r.mag = tvsl_pkg::STICK_RADIUS;
    end else begin
      r.mag = m[tvsl_pkg::MAG_W-1:0];
    end
    return r;
  endfunction

  // Clamp a widened pixel sum to the symmetric limit
  function automatic logic signed [tvsl_pkg::SUM_W-1:0] sat_sum(
      input logic signed [tvsl_pkg::SUM_W:0] v);
    logic signed [tvsl_pkg::SUM_W:0] r;
    if (v > tvsl_pkg::SUM_LIMIT) begin
      r = tvsl_pkg::SUM_LIMIT;
    end else if (v < -tvsl_pkg::SUM_LIMIT) begin
      r = -tvsl_pkg::SUM_LIMIT;
    end else begin
      r = v;
    end
    return r[tvsl_pkg::SUM_W-1:0];
  endfunction

  // Configuration registers
  logic [tvsl_pkg::POS_W-1:0]  half_width;
  logic [7:0]                  stick_deadzone;
  logic [15:0]                 tap_travel_limit;
  logic [tvsl_pkg::TIME_W-1:0] tap_time_limit_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width        <= 12'd240;
      stick_deadzone    <= 8'd8;
      tap_travel_limit  <= 16'd12;
      tap_time_limit_us <= 32'd240000;
    end else if (cfg_we) begin
      case (cfg_addr)
        tvsl_pkg::CFG_HALF_WIDTH: half_width        <= cfg_data[tvsl_pkg::POS_W-1:0];
        tvsl_pkg::CFG_DEADZONE:   stick_deadzone    <= cfg_data[7:0];
        tvsl_pkg::CFG_TAP_TRAVEL: tap_travel_limit  <= cfg_data[15:0];
        tvsl_pkg::CFG_TAP_TIME:   tap_time_limit_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic            a_valid;
  tvsl_pkg::item_t a_item;
  logic            is_consume;
  logic            a_adv;

  assign is_consume = (a_item.cmd == tvsl_pkg::CMD_CONSUME);
  assign a_adv      = a_valid && (!is_consume || !snap_valid || snap_ready);
  assign in_ready   = !a_valid || a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_item <= in_item;
    end
  end

  // Tracking state
  logic                           stick_active, stick_active_next;
  logic [tvsl_pkg::ID_W-1:0]      stick_finger, stick_finger_next;
  logic [tvsl_pkg::POS_W-1:0]     stick_origin_x, stick_origin_x_next;
  logic [tvsl_pkg::POS_W-1:0]     stick_origin_y, stick_origin_y_next;
  logic [tvsl_pkg::POS_W-1:0]     stick_cur_x, stick_cur_x_next;
  logic [tvsl_pkg::POS_W-1:0]     stick_cur_y, stick_cur_y_next;
  logic                           look_active, look_active_next;
  logic [tvsl_pkg::ID_W-1:0]      look_finger, look_finger_next;
  logic [tvsl_pkg::POS_W-1:0]     look_cur_x, look_cur_x_next;
  logic [tvsl_pkg::POS_W-1:0]     look_cur_y, look_cur_y_next;
  logic [15:0]                    look_travel, look_travel_next;
  logic [tvsl_pkg::TIME_W-1:0]    look_press_time, look_press_time_next;
  logic signed [tvsl_pkg::SUM_W-1:0] orbit_pixel_sum, orbit_pixel_sum_next;
  logic signed [tvsl_pkg::SUM_W-1:0] tilt_pixel_sum, tilt_pixel_sum_next;
  logic                           jump_pending, jump_pending_next;

  // Look-move arithmetic
  logic                           stick_hit, look_hit;
  logic signed [tvsl_pkg::POS_W:0] dx, dy;
  logic [tvsl_pkg::POS_W-1:0]     adx, ady;
  logic [16:0]                    travel_sum;
  logic [tvsl_pkg::TIME_W-1:0]    press_len;
  logic                           is_tap;

  assign stick_hit  = stick_active && (stick_finger == a_item.touch_id);
  assign look_hit   = look_active && (look_finger == a_item.touch_id) && !stick_hit;
  assign dx         = $signed({1'b0, a_item.pos_x}) - $signed({1'b0, look_cur_x});
  assign dy         = $signed({1'b0, a_item.pos_y}) - $signed({1'b0, look_cur_y});
  assign adx        = dx[tvsl_pkg::POS_W] ? tvsl_pkg::POS_W'(-dx) : dx[tvsl_pkg::POS_W-1:0];
  assign ady        = dy[tvsl_pkg::POS_W] ? tvsl_pkg::POS_W'(-dy) : dy[tvsl_pkg::POS_W-1:0];
  assign travel_sum = {1'b0, look_travel} + {5'd0, adx} + {5'd0, ady};
  assign press_len  = a_item.time_us - look_press_time;
  assign is_tap     = (look_travel < tap_travel_limit) && (press_len < tap_time_limit_us);

  // Next state for the word in the input register
  always_comb begin
    stick_active_next    = stick_active;
    stick_finger_next    = stick_finger;
    stick_origin_x_next  = stick_origin_x;
    stick_origin_y_next  = stick_origin_y;
    stick_cur_x_next     = stick_cur_x;
    stick_cur_y_next     = stick_cur_y;
    look_active_next     = look_active;
    look_finger_next     = look_finger;
    look_cur_x_next      = look_cur_x;
    look_cur_y_next      = look_cur_y;
    look_travel_next     = look_travel;
    look_press_time_next = look_press_time;
    orbit_pixel_sum_next = orbit_pixel_sum;
    tilt_pixel_sum_next  = tilt_pixel_sum;
    jump_pending_next    = jump_pending;
    case (a_item.cmd)
      tvsl_pkg::CMD_DOWN: begin
        if (a_item.pos_x < half_width) begin
          if (!stick_active) begin
            stick_active_next   = 1'b1;
            stick_finger_next   = a_item.touch_id;
            stick_origin_x_next = a_item.pos_x;
            stick_origin_y_next = a_item.pos_y;
            stick_cur_x_next    = a_item.pos_x;
            stick_cur_y_next    = a_item.pos_y;
          end
        end else if (!look_active) begin
          look_active_next     = 1'b1;
          look_finger_next     = a_item.touch_id;
          look_cur_x_next      = a_item.pos_x;
          look_cur_y_next      = a_item.pos_y;
          look_travel_next     = '0;
          look_press_time_next = a_item.time_us;
        end
      end
      tvsl_pkg::CMD_MOVE: begin
        if (stick_hit) begin
          stick_cur_x_next = a_item.pos_x;
          stick_cur_y_next = a_item.pos_y;
        end else if (look_hit) begin
          look_travel_next     = travel_sum[16] ? 16'hFFFF : travel_sum[15:0];
          orbit_pixel_sum_next = sat_sum(orbit_pixel_sum + 17'(dx));
          tilt_pixel_sum_next  = sat_sum(tilt_pixel_sum - 17'(dy));
          look_cur_x_next      = a_item.pos_x;
          look_cur_y_next      = a_item.pos_y;
        end
      end
      tvsl_pkg::CMD_UP, tvsl_pkg::CMD_CANCEL: begin
        if (stick_hit) begin
          stick_active_next = 1'b0;
        end else if (look_hit) begin
          if ((a_item.cmd == tvsl_pkg::CMD_UP) && is_tap) begin
            jump_pending_next = 1'b1;
          end
          look_active_next = 1'b0;
        end
      end
      tvsl_pkg::CMD_CONFIRM: begin
        jump_pending_next = 1'b1;
      end
      tvsl_pkg::CMD_CONSUME: begin
        orbit_pixel_sum_next = '0;
        tilt_pixel_sum_next  = '0;
        jump_pending_next    = 1'b0;
      end
      default: ;
    endcase
  end

  // Commit state when the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stick_active    <= 1'b0;
      stick_finger    <= '0;
      stick_origin_x  <= '0;
      stick_origin_y  <= '0;
      stick_cur_x     <= '0;
      stick_cur_y     <= '0;
      look_active     <= 1'b0;
      look_finger     <= '0;
      look_cur_x      <= '0;
      look_cur_y      <= '0;
      look_travel     <= '0;
      look_press_time <= '0;
      orbit_pixel_sum <= '0;
      tilt_pixel_sum  <= '0;
      jump_pending    <= 1'b0;
    end else if (a_adv) begin
      stick_active    <= stick_active_next;
      stick_finger    <= stick_finger_next;
      stick_origin_x  <= stick_origin_x_next;
      stick_origin_y  <= stick_origin_y_next;
      stick_cur_x     <= stick_cur_x_next;
      stick_cur_y     <= stick_cur_y_next;
      look_active     <= look_active_next;
      look_finger     <= look_finger_next;
      look_cur_x      <= look_cur_x_next;
      look_cur_y      <= look_cur_y_next;
      look_travel     <= look_travel_next;
      look_press_time <= look_press_time_next;
      orbit_pixel_sum <= orbit_pixel_sum_next;
      tilt_pixel_sum  <= tilt_pixel_sum_next;
      jump_pending    <= jump_pending_next;
    end
  end

  // Snapshot register for a consume
  defl_t fwd_d, str_d;

  assign fwd_d = defl_prep(stick_cur_y, stick_origin_y, stick_deadzone);
  assign str_d = defl_prep(stick_cur_x, stick_origin_x, stick_deadzone);

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (a_adv && is_consume) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && is_consume) begin
      snap.fwd_neg   <= fwd_d.neg;
      snap.fwd_mag   <= stick_active ? fwd_d.mag : '0;
      snap.str_neg   <= str_d.neg;
      snap.str_mag   <= stick_active ? str_d.mag : '0;
      snap.orbit_sum <= orbit_pixel_sum;
      snap.tilt_sum  <= tilt_pixel_sum;
      snap.jump      <= jump_pending;
    end
  end

endmodule

// File: sv/tvsl_scale.sv
// ----------------------------------------------------------------------------
// tvsl_scale
// Result stage: scales a consume snapshot to stick deflections and look
// angles and holds the finished word in the output register.
// ----------------------------------------------------------------------------
module tvsl_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             snap_valid,
  output logic                             snap_ready,
  input  tvsl_pkg::snap_t                  snap,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tvsl_pkg::STICK_W-1:0] forward,
  output logic signed [tvsl_pkg::STICK_W-1:0] strafe,
  output logic signed [tvsl_pkg::ORBIT_W-1:0] orbit,
  output logic signed [tvsl_pkg::TILT_W-1:0]  tilt,
  output logic                             jump
);

  // Deflection: magnitude times 16384/70, truncated
  logic [30:0]            fwd_prod, str_prod;
  logic [14:0]            fwd_q, str_q;
  logic signed [15:0]     fwd_val, str_val;

  assign fwd_prod = {24'd0, snap.fwd_mag} * {7'd0, tvsl_pkg::DEFL_RECIP};
  assign str_prod = {24'd0, snap.str_mag} * {7'd0, tvsl_pkg::DEFL_RECIP};
  assign fwd_q    = fwd_prod[tvsl_pkg::DEFL_SHIFT+14:tvsl_pkg::DEFL_SHIFT];
  assign str_q    = str_prod[tvsl_pkg::DEFL_SHIFT+14:tvsl_pkg::DEFL_SHIFT];
  // Forward is the negated vertical deflection
  assign fwd_val  = snap.fwd_neg ? $signed({1'b0, fwd_q}) : -$signed({1'b0, fwd_q});
  assign str_val  = snap.str_neg ? -$signed({1'b0, str_q}) : $signed({1'b0, str_q});

  // Look angles: round-half-up then floor by 128
  logic signed [33:0] orbit_prod, tilt_prod;
  logic signed [33:0] orbit_rnd, tilt_rnd;

  assign orbit_prod = snap.orbit_sum * $signed({1'b0, tvsl_pkg::ORBIT_MUL});
  assign tilt_prod  = snap.tilt_sum * $signed({1'b0, tvsl_pkg::TILT_MUL});
  assign orbit_rnd  = orbit_prod + 34'sd64;
  assign tilt_rnd   = tilt_prod + 34'sd64;

  // Output register
  assign snap_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      forward <= fwd_val;
      strafe  <= str_val;
      orbit   <= orbit_rnd[32:7];
      tilt    <= tilt_rnd[31:7];
      jump    <= snap.jump;
    end
  end

endmodule

// File: sv/touch_virtual_stick_and_look_unit.sv
// ----------------------------------------------------------------------------
// touch_virtual_stick_and_look_unit
// Virtual joystick and look pad from touch events, with tap-to-jump.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: cmd; tdata: id, x, y, time
//   m_*      out  m_tvalid/m_tready  tdata: forward, strafe, orbit, tilt, jump
//   cfg_*    in   cfg_we             cfg_addr index, cfg_data value
//
// One word per cycle sustained unless a consume waits on a stalled output.
// Each word is held in the input register, where the tracking state is
// updated; a consume then goes through a snapshot register and the output
// register. Reset is synchronous and restores the register defaults and
// clears all tracking state. A stalled output holds only consume words;
// other events keep flowing while a result waits.
// ----------------------------------------------------------------------------
module touch_virtual_stick_and_look_unit (
  input  logic                       clk,
  input  logic                       rst,
  // cfg
  input  logic                       cfg_we,
  input  logic [tvsl_pkg::IDX_W-1:0] cfg_addr,
  input  logic [tvsl_pkg::CFG_W-1:0] cfg_data,
  // input events
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tvsl_pkg::IN_W-1:0]  s_tdata,   // touch_id, pos_x, pos_y, time_us
  input  logic [tvsl_pkg::CMD_W-1:0] s_tuser,   // cmd
  // results
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [tvsl_pkg::OUT_W-1:0] m_tdata    // forward, strafe, orbit, tilt, jump
);

  tvsl_pkg::item_t in_item;
  tvsl_pkg::snap_t snap;
  logic            snap_valid;
  logic            snap_ready;

  logic signed [tvsl_pkg::STICK_W-1:0] forward;
  logic signed [tvsl_pkg::STICK_W-1:0] strafe;
  logic signed [tvsl_pkg::ORBIT_W-1:0] orbit;
  logic signed [tvsl_pkg::TILT_W-1:0]  tilt;
  logic                                jump;

  // Unpack the input word
  assign in_item.cmd      = s_tuser;
  assign in_item.touch_id = s_tdata[15:0];
  assign in_item.pos_x    = s_tdata[27:16];
  assign in_item.pos_y    = s_tdata[39:28];
  assign in_item.time_us  = s_tdata[71:40];

  tvsl_track u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  tvsl_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .forward    (forward),
    .strafe     (strafe),
    .orbit      (orbit),
    .tilt       (tilt),
    .jump       (jump)
  );

  // Pack the result word, zero fill to a whole byte
  assign m_tdata = {4'd0, jump, tilt, orbit, strafe, forward};

endmodule
